@@ design/owrb_pkg.sv @@
// Shared types and constants of the overwriting byte ring FIFO.
`default_nettype none

package owrb_pkg;

  localparam int unsigned DefaultDepth = 64;
  localparam int unsigned OpW          = 2;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned CountW       = 7;
  localparam int unsigned SlotW        = 16;
  localparam int unsigned FillW        = 7;

  // longest bulk run served by one request
  localparam logic [CountW-1:0] MaxRun = CountW'(64);

  localparam logic [OpW-1:0] OP_PUSH  = 2'd0;
  localparam logic [OpW-1:0] OP_POP   = 2'd1;
  localparam logic [OpW-1:0] OP_BULK  = 2'd2;
  localparam logic [OpW-1:0] OP_CLEAR = 2'd3;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_BULK,
    CMD_CLEAR
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [ByteW-1:0]   data;
    logic [CountW-1:0]  count;
    logic [SlotW-1:0]   slot;
  } cmd_t;

endpackage

`default_nettype wire

@@ design/owrb_in_if.sv @@
// Request channel of the ring FIFO: valid/ready plus one request.
`default_nettype none

interface owrb_in_if;
  logic                           valid;
  logic                           ready;
  logic [owrb_pkg::OpW-1:0]       op;
  logic [owrb_pkg::ByteW-1:0]     data;
  logic [owrb_pkg::CountW-1:0]    count;
  logic [owrb_pkg::SlotW-1:0]     start_slot;

  modport source (output valid, output op, output data, output count, output start_slot,
                  input ready);
  modport sink (input valid, input op, input data, input count, input start_slot,
                output ready);
endinterface

`default_nettype wire

@@ design/owrb_out_if.sv @@
// Result channel of the ring FIFO: valid/ready plus one result.
`default_nettype none

interface owrb_out_if;
  logic                           valid;
  logic                           ready;
  logic [owrb_pkg::ByteW-1:0]     byte_out;
  logic                           byte_valid;
  logic [owrb_pkg::SlotW-1:0]     slot;
  logic                           last;
  logic [owrb_pkg::FillW-1:0]     fill_level;
  logic                           is_full;
  logic                           is_empty;
  logic                           wrapped;

  modport source (output valid, output byte_out, output byte_valid, output slot,
                  output last, output fill_level, output is_full, output is_empty,
                  output wrapped, input ready);
  modport sink (input valid, input byte_out, input byte_valid, input slot, input last,
                input fill_level, input is_full, input is_empty, input wrapped,
                output ready);
endinterface

`default_nettype wire

@@ design/owrb_front.sv @@
// Front end: takes requests, decodes them into commands and registers them.
`default_nettype none

module owrb_front (
  input  wire            clk_i,
  input  wire            rst_ni,
  owrb_in_if.sink        in_i,
  output logic           cmd_valid_o,
  output owrb_pkg::cmd_t cmd_o,
  input  wire            cmd_ready_i
);

  logic           valid_q, valid_d;
  owrb_pkg::cmd_t cmd_q, cmd_d;
  logic           take;

  assign in_i.ready = !valid_q || cmd_ready_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    cmd_d      = cmd_q;
    cmd_d.data = in_i.data;
    cmd_d.slot = in_i.start_slot;
    // runs longer than the ring can ever serve are cut here
    cmd_d.count = (in_i.count > owrb_pkg::MaxRun) ? owrb_pkg::MaxRun : in_i.count;
    case (in_i.op)
      owrb_pkg::OP_PUSH:  cmd_d.kind = owrb_pkg::CMD_PUSH;
      owrb_pkg::OP_POP:   cmd_d.kind = owrb_pkg::CMD_POP;
      owrb_pkg::OP_BULK:  cmd_d.kind = owrb_pkg::CMD_BULK;
      owrb_pkg::OP_CLEAR: cmd_d.kind = owrb_pkg::CMD_CLEAR;
      default:            cmd_d.kind = owrb_pkg::CMD_CLEAR;
    endcase
  end

  assign valid_d = take || (valid_q && !cmd_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

`default_nettype wire

@@ design/owrb_cmd_queue.sv @@
// Two-entry command queue between the front and back ends.
`default_nettype none

module owrb_cmd_queue (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            wr_valid_i,
  output logic           wr_ready_o,
  input  owrb_pkg::cmd_t wr_cmd_i,
  output logic           rd_valid_o,
  input  wire            rd_pop_i,
  output owrb_pkg::cmd_t rd_cmd_o
);

  owrb_pkg::cmd_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     used_q, used_d;
  logic           push, pop;

  assign wr_ready_o = (used_q != 2'd2);
  assign rd_valid_o = (used_q != 2'd0);
  assign rd_cmd_o   = entry_q[rd_ptr_q];

  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_pop_i && rd_valid_o;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    used_d   = used_q;
    if (push && !pop) begin
      used_d = used_q + 2'd1;
    end else if (pop && !push) begin
      used_d = used_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      used_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      used_q   <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

`default_nettype wire

@@ design/owrb_back.sv @@
// Back end: ring storage, pointers and flags, bulk sequencing, result register.
`default_nettype none

module owrb_back #(
  parameter int unsigned DEPTH = owrb_pkg::DefaultDepth
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            cmd_valid_i,
  input  owrb_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  owrb_out_if.source     out_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = (PW + 1 > owrb_pkg::FillW) ? PW + 1 : owrb_pkg::FillW;
  localparam logic [PW-1:0] LastIdx = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DepthC  = CW'(DEPTH);

  localparam int unsigned BW = owrb_pkg::ByteW;
  localparam int unsigned NW = owrb_pkg::CountW;
  localparam int unsigned SW = owrb_pkg::SlotW;

  logic [BW-1:0] mem [DEPTH];

  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic          lap_q, lap_d, full_q, full_d, empty_q, empty_d;
  logic          active_q, active_d;
  logic [NW-1:0] run_n_q, run_i_q;

  logic          ovalid_q;
  logic [BW-1:0] byte_q;
  logic          bvalid_q, last_q, full_o_q, empty_o_q, lap_o_q;
  logic [SW-1:0] slot_q;
  logic [owrb_pkg::FillW-1:0] fill_q;

  logic          go;
  logic [CW-1:0] fill_c, fill_n;
  logic [NW-1:0] n_new, run_n, run_i;
  logic          run_last;

  // next state of a single pop and of a push
  logic [PW-1:0] rp_inc, pop_wp, wp_inc, push_rp;
  logic          pop_lap, pop_empty, push_lap, push_full;

  logic          res_read, res_last;
  logic [SW-1:0] res_slot;

  assign go = cmd_valid_i && (!ovalid_q || out_o.ready);

  assign fill_c = lap_q ? DepthC + CW'(wp_q) - CW'(rp_q) : CW'(wp_q) - CW'(rp_q);
  assign n_new  = (CW'(cmd_i.count) < fill_c) ? cmd_i.count : NW'(fill_c);
  assign run_n  = active_q ? run_n_q : n_new;
  assign run_i  = active_q ? run_i_q : '0;
  assign run_last = (run_n == '0) || (run_i == run_n - NW'(1));

  assign rp_inc    = (rp_q == LastIdx) ? '0 : rp_q + PW'(1);
  assign pop_lap   = (rp_q == LastIdx) ? 1'b0 : lap_q;
  assign pop_wp    = empty_q ? rp_inc : wp_q;
  assign pop_empty = !pop_lap && (pop_wp == rp_inc);

  assign wp_inc    = (wp_q == LastIdx) ? '0 : wp_q + PW'(1);
  assign push_lap  = (wp_q == LastIdx) ? 1'b1 : lap_q;
  assign push_rp   = full_q ? wp_inc : rp_q;
  assign push_full = push_lap && (wp_inc == push_rp);

  always_comb begin
    wp_d     = wp_q;
    rp_d     = rp_q;
    lap_d    = lap_q;
    full_d   = full_q;
    empty_d  = empty_q;
    res_read = 1'b0;
    res_slot = '0;
    res_last = 1'b1;
    case (cmd_i.kind)
      owrb_pkg::CMD_PUSH: begin
        wp_d    = wp_inc;
        rp_d    = push_rp;
        lap_d   = push_lap;
        full_d  = push_full;
        empty_d = 1'b0;
      end
      owrb_pkg::CMD_POP: begin
        wp_d     = pop_wp;
        rp_d     = rp_inc;
        lap_d    = pop_lap;
        full_d   = 1'b0;
        empty_d  = pop_empty;
        res_read = !empty_q;
      end
      owrb_pkg::CMD_BULK: begin
        if (run_n != '0) begin
          wp_d     = pop_wp;
          rp_d     = rp_inc;
          lap_d    = pop_lap;
          full_d   = 1'b0;
          empty_d  = pop_empty;
          res_read = !empty_q;
          res_slot = cmd_i.slot + SW'(run_i);
          res_last = run_last;
        end
      end
      owrb_pkg::CMD_CLEAR: begin
        wp_d    = '0;
        rp_d    = '0;
        lap_d   = 1'b0;
        full_d  = 1'b0;
        empty_d = 1'b1;
      end
      default: begin
        wp_d = wp_q;
      end
    endcase
  end

  assign fill_n = lap_d ? DepthC + CW'(wp_d) - CW'(rp_d) : CW'(wp_d) - CW'(rp_d);

  // head stays in the queue until the last byte of a bulk run is out
  assign cmd_pop_o = go && !((cmd_i.kind == owrb_pkg::CMD_BULK) && !run_last);
  assign active_d  = (go && (cmd_i.kind == owrb_pkg::CMD_BULK)) ? !run_last : active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      rp_q     <= '0;
      lap_q    <= 1'b0;
      full_q   <= 1'b0;
      empty_q  <= 1'b1;
      active_q <= 1'b0;
      run_n_q  <= '0;
      run_i_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      if (go) begin
        wp_q     <= wp_d;
        rp_q     <= rp_d;
        lap_q    <= lap_d;
        full_q   <= full_d;
        empty_q  <= empty_d;
        run_n_q  <= run_n;
        run_i_q  <= run_i + NW'(1);
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && (cmd_i.kind == owrb_pkg::CMD_PUSH)) begin
      mem[wp_q] <= cmd_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      byte_q    <= res_read ? mem[rp_q] : '0;
      bvalid_q  <= res_read;
      slot_q    <= res_slot;
      last_q    <= res_last;
      fill_q    <= fill_n[owrb_pkg::FillW-1:0];
      full_o_q  <= full_d;
      empty_o_q <= empty_d;
      lap_o_q   <= lap_d;
    end
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.byte_out   = byte_q;
  assign out_o.byte_valid = bvalid_q;
  assign out_o.slot       = slot_q;
  assign out_o.last       = last_q;
  assign out_o.fill_level = fill_q;
  assign out_o.is_full    = full_o_q;
  assign out_o.is_empty   = empty_o_q;
  assign out_o.wrapped    = lap_o_q;

endmodule

`default_nettype wire

@@ design/overwrite_ring_byte_fifo_unit.sv @@
// Top level of the overwriting byte ring FIFO.
//
// Byte ring of DEPTH entries that overwrites its oldest byte when full. Requests
// (push, single pop, bulk pop, clear) pass a register stage and a two-entry command
// queue, so up to three requests wait behind a result that is held back. The back end
// executes one ring operation per clock unless a result is held back: push, single
// pop and clear give one result each, a bulk pop of n bytes (n = min(count, fill, 64))
// gives n results, or one status result when n is zero. Throughput is therefore one
// result per cycle while no result is held back. Each request passes the front register,
// a command queue entry and the result register. The storage needs no clearing after
// reset; pointers and flags reset at once.
`default_nettype none

module overwrite_ring_byte_fifo_unit #(
  parameter int unsigned DEPTH = owrb_pkg::DefaultDepth
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  owrb_in_if.sink    in_i,
  owrb_out_if.source out_o
);

  logic           fe_valid, fe_ready;
  owrb_pkg::cmd_t fe_cmd;
  logic           q_valid, q_pop;
  owrb_pkg::cmd_t q_cmd;

  owrb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (fe_valid),
    .cmd_o       (fe_cmd),
    .cmd_ready_i (fe_ready)
  );

  owrb_cmd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fe_valid),
    .wr_ready_o (fe_ready),
    .wr_cmd_i   (fe_cmd),
    .rd_valid_o (q_valid),
    .rd_pop_i   (q_pop),
    .rd_cmd_o   (q_cmd)
  );

  owrb_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
